// ----- design/mlpq_pkg.sv -----
// Shared types and constants for the multi-level priority queue.
package mlpq_pkg;

	localparam int LEVELS_DEF          = 4;
	localparam int DEPTH_PER_LEVEL_DEF = 16;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic    push_ok;
		logic    pop_ok;
		status_t status;
	} mlpq_dec_t;

endpackage

// ----- design/multi_level_priority_queue.sv -----
// Multi-level priority queue: one FIFO of signed 32-bit values per level.
// Input channel in_valid/in_ready carries a request: op (push or pop), value
// and priority_req. Output channel out_valid/out_ready returns one result per
// request: popped_value, served_level and status (ok, empty or full).
// A push appends value to its level; a pop takes the oldest entry of the
// most urgent non-empty level, level 0 being the most urgent.
// A request is taken into the input register and then moves into the output
// register, where its result is held. Throughput: one request per cycle while
// the receiver keeps out_ready high; the level encoder and the single-port entry
// store each serve one request per cycle.
// If the receiver stalls, the result holds and one more request is still
// taken into the input register; after that in_ready drops until out_ready.
// Reset empties every level at once; no clearing pass runs and the first
// request may follow reset directly.
module multi_level_priority_queue #(
	parameter int LEVELS          = mlpq_pkg::LEVELS_DEF,
	parameter int DEPTH_PER_LEVEL = mlpq_pkg::DEPTH_PER_LEVEL_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic signed [31:0] value,
	input  logic        [1:0]  priority_req,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] popped_value,
	output logic        [1:0]  served_level,
	output logic        [1:0]  status
);
	import mlpq_pkg::*;

	localparam int LVL_W   = $clog2(LEVELS);
	localparam int ENTRIES = LEVELS * DEPTH_PER_LEVEL;
	localparam int ADDR_W  = $clog2(ENTRIES);

	logic               valid_s1;
	logic               op_s1;
	logic signed [31:0] value_s1;
	logic        [1:0]  prio_s1;

	logic               valid_s2;
	logic               pop_ok_s2;
	status_t            status_s2;
	logic        [1:0]  level_s2;
	logic signed [31:0] rdata_s2;

	logic               advance;
	mlpq_dec_t          dec;
	logic [ADDR_W-1:0]  addr;
	logic [LVL_W-1:0]   pop_level;

	logic signed [31:0] mem [ENTRIES];

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	mlpq_ctrl #(
		.LEVELS          (LEVELS),
		.DEPTH_PER_LEVEL (DEPTH_PER_LEVEL)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op_s1),
		.priority_req (prio_s1),
		.advance      (advance),
		.dec          (dec),
		.addr         (addr),
		.pop_level    (pop_level)
	);

	// hold the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= op;
			value_s1 <= value;
			prio_s1  <= priority_req;
		end
	end

	// advance into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pop_ok_s2 <= dec.pop_ok;
			status_s2 <= dec.status;
			level_s2  <= dec.pop_ok ? 2'(pop_level) : 2'b00;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dec.push_ok) begin
			mem[addr] <= value_s1;
		end
		if (advance && dec.pop_ok) begin
			rdata_s2 <= mem[addr];
		end
	end

	assign out_valid    = valid_s2;
	assign popped_value = pop_ok_s2 ? rdata_s2 : 32'sd0;
	assign served_level = level_s2;
	assign status       = status_s2;

endmodule

// ----- design/mlpq_ctrl.sv -----
// Level bookkeeping: counts, read and write slots, and the urgency encoder.
module mlpq_ctrl #(
	parameter int LEVELS          = mlpq_pkg::LEVELS_DEF,
	parameter int DEPTH_PER_LEVEL = mlpq_pkg::DEPTH_PER_LEVEL_DEF,
	localparam int LVL_W  = $clog2(LEVELS),
	localparam int ADDR_W = $clog2(LEVELS * DEPTH_PER_LEVEL)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  op,
	input  logic [1:0]            priority_req,
	input  logic                  advance,
	output mlpq_pkg::mlpq_dec_t   dec,
	output logic [ADDR_W-1:0]     addr,
	output logic [LVL_W-1:0]      pop_level
);
	import mlpq_pkg::*;

	localparam int SLOT_W = $clog2(DEPTH_PER_LEVEL);
	localparam int CNT_W  = $clog2(DEPTH_PER_LEVEL + 1);
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(DEPTH_PER_LEVEL);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(DEPTH_PER_LEVEL - 1);
	localparam logic [ADDR_W-1:0] DEPTH_A   = ADDR_W'(DEPTH_PER_LEVEL);

	logic [CNT_W-1:0]  cnt_q  [LEVELS];
	logic [SLOT_W-1:0] head_q [LEVELS];
	logic [SLOT_W-1:0] tail_q [LEVELS];

	logic              found;
	logic [LVL_W-1:0]  pop_idx;
	logic [LVL_W-1:0]  push_idx;
	logic              lvl_in;
	logic              full;
	logic [LVL_W-1:0]  sel_idx;
	logic [SLOT_W-1:0] sel_slot;
	logic [SLOT_W-1:0] head_nxt;
	logic [SLOT_W-1:0] tail_nxt;

	always_comb begin
		found   = 1'b0;
		pop_idx = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				found   = 1'b1;
				pop_idx = LVL_W'(i);
			end
		end
	end

	assign push_idx = LVL_W'(priority_req);
	assign lvl_in   = 32'(priority_req) < 32'(LEVELS);
	assign full     = cnt_q[push_idx] == CNT_FULL;

	always_comb begin
		dec.push_ok = (op == OP_PUSH) && lvl_in && !full;
		dec.pop_ok  = (op == OP_POP) && found;
		if (op == OP_PUSH) begin
			dec.status = dec.push_ok ? ST_OK : ST_FULL;
		end else begin
			dec.status = found ? ST_OK : ST_EMPTY;
		end
	end

	assign sel_idx   = (op == OP_PUSH) ? push_idx : pop_idx;
	assign sel_slot  = (op == OP_PUSH) ? tail_q[push_idx] : head_q[pop_idx];
	assign addr      = ADDR_W'(sel_idx) * DEPTH_A + ADDR_W'(sel_slot);
	assign pop_level = pop_idx;

	assign head_nxt = (head_q[pop_idx] == SLOT_LAST) ? '0 : head_q[pop_idx] + 1'b1;
	assign tail_nxt = (tail_q[push_idx] == SLOT_LAST) ? '0 : tail_q[push_idx] + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else if (advance) begin
			if (dec.push_ok) begin
				tail_q[push_idx] <= tail_nxt;
				cnt_q[push_idx]  <= cnt_q[push_idx] + 1'b1;
			end
			if (dec.pop_ok) begin
				head_q[pop_idx] <= head_nxt;
				cnt_q[pop_idx]  <= cnt_q[pop_idx] - 1'b1;
			end
		end
	end

endmodule
